[rtl/core/lrd_pkg.sv]
// Shared types and constants for the DDA line rasterizer.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package lrd_pkg;

  // Default geometry of the fixed-point walk.
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Port widths fixed by the item format.
  localparam int PORT_BITS    = 16;
  localparam int CFG_IDX_BITS = 1;

  // Register reset values.
  localparam logic [PORT_BITS-1:0] IMAGE_WIDTH_RST  = 16'd640;
  localparam logic [PORT_BITS-1:0] IMAGE_HEIGHT_RST = 16'd480;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // Input item commands.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [PORT_BITS-1:0] start_x;
    logic [PORT_BITS-1:0] start_y;
    logic [PORT_BITS-1:0] end_x;
    logic [PORT_BITS-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [PORT_BITS-1:0] pixel_x;
    logic [PORT_BITS-1:0] pixel_y;
    logic                 inside_res;
    logic                 last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture endpoints of a new line
    logic div_init;    // load the slope divider
    logic div_iter;    // one quotient bit
    logic step_store;  // latch the signed step and start the walk
    logic pixel;       // emit one pixel and advance
    logic out_take;    // downstream takes the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic active;
    logic no_div;
    logic div_done;
    logic out_valid;
  } dp_status_t;

endpackage

[rtl/core/lrd_div.sv]
// Restoring divider for the slope: ((dmin << FRAC) + dmaj/2) / dmaj.
// One quotient bit per cycle, FRAC_BITS+1 iterations; uses lrd_pkg defaults.
`timescale 1ns / 1ps

module lrd_div #(
  parameter int COORD_BITS = lrd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lrd_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  init,
  input  logic                  iter,
  input  logic [COORD_BITS-1:0] dmin,
  input  logic [COORD_BITS-1:0] dmaj,
  output logic [FRAC_BITS:0]    quot,
  output logic                  done
);

  localparam int NUM_BITS = COORD_BITS + FRAC_BITS + 1;
  localparam int CNT_BITS = $clog2(FRAC_BITS + 2);

  logic [COORD_BITS-1:0] rem_r, rem_nxt;
  logic [FRAC_BITS:0]    lo_r, lo_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [NUM_BITS-1:0]   num;
  logic [COORD_BITS:0]   trial;
  logic                  ge;

  // Rounded numerator. The quotient fits FRAC_BITS+1 bits since dmin <= dmaj,
  // so the upper numerator bits already form a remainder below the divisor.
  assign num = (NUM_BITS'(dmin) << FRAC_BITS) + NUM_BITS'(dmaj >> 1);

  // Trial subtraction for one quotient bit.
  assign trial = {rem_r, lo_r[FRAC_BITS]};
  assign ge    = trial >= {1'b0, dmaj};

  always_comb begin
    rem_nxt = rem_r;
    lo_nxt  = lo_r;
    cnt_nxt = cnt_r;
    if (init) begin
      rem_nxt = num[NUM_BITS-1:FRAC_BITS+1];
      lo_nxt  = num[FRAC_BITS:0];
      cnt_nxt = '0;
    end else if (iter) begin
      rem_nxt = ge ? COORD_BITS'(trial - {1'b0, dmaj}) : trial[COORD_BITS-1:0];
      lo_nxt  = {lo_r[FRAC_BITS-1:0], ge};
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Count register is control state; remainder and quotient are payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
  end

  assign quot = lo_r;
  assign done = cnt_r == CNT_BITS'(FRAC_BITS + 1);

endmodule

[rtl/core/lrd_dp.sv]
// Datapath of the line rasterizer: endpoint ordering, slope divider, walk
// registers, configuration registers and the output register. Uses lrd_pkg, lrd_div.
`timescale 1ns / 1ps

module lrd_dp #(
  parameter int COORD_BITS = lrd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lrd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lrd_pkg::ctrl_cmd_t                cmd,
  output lrd_pkg::dp_status_t               status,
  input  lrd_pkg::in_item_t                 in_item,
  input  logic                              cfg_we,
  input  logic [lrd_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [lrd_pkg::PORT_BITS-1:0]     cfg_data,
  output lrd_pkg::out_item_t                out_item,
  output logic                              out_valid
);

  localparam int ACC_BITS = COORD_BITS + FRAC_BITS;

  // Configuration registers.
  logic [lrd_pkg::PORT_BITS-1:0] width_r, height_r;

  // Line state.
  logic                  active_r, active_nxt;
  logic                  steep_r, steep_nxt;
  logic                  neg_r, neg_nxt;
  logic [COORD_BITS-1:0] major_pos_r, major_pos_nxt;
  logic [COORD_BITS-1:0] major_end_r, major_end_nxt;
  logic [COORD_BITS-1:0] dmin_r, dmin_nxt;
  logic [COORD_BITS-1:0] dmaj_r, dmaj_nxt;
  logic [ACC_BITS-1:0]   minor_acc_r, minor_acc_nxt;
  logic [ACC_BITS-1:0]   minor_step_r, minor_step_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  lrd_pkg::out_item_t out_r, out_nxt;

  // Endpoint ordering.
  logic [COORD_BITS-1:0] x0, y0, x1, y1, dx, dy;
  logic [COORD_BITS-1:0] maj0, maj1, min0, min1, m_lo, m_hi;
  logic                  steep_in, swap;

  // Divider and pixel signals.
  logic [FRAC_BITS:0]     quot;
  logic                   div_done;
  logic [ACC_BITS-1:0]    quot_ext;
  logic [COORD_BITS-1:0]  minor;
  logic [lrd_pkg::PORT_BITS-1:0] px, py;
  logic                   is_last;

  // Major axis choice and endpoint order for a start item.
  always_comb begin
    x0       = in_item.start_x[COORD_BITS-1:0];
    y0       = in_item.start_y[COORD_BITS-1:0];
    x1       = in_item.end_x[COORD_BITS-1:0];
    y1       = in_item.end_y[COORD_BITS-1:0];
    dx       = (x0 > x1) ? (x0 - x1) : (x1 - x0);
    dy       = (y0 > y1) ? (y0 - y1) : (y1 - y0);
    steep_in = dy > dx;
    maj0     = steep_in ? y0 : x0;
    maj1     = steep_in ? y1 : x1;
    min0     = steep_in ? x0 : y0;
    min1     = steep_in ? x1 : y1;
    swap     = maj0 > maj1;
    m_lo     = swap ? min1 : min0;
    m_hi     = swap ? min0 : min1;
  end

  lrd_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .init  (cmd.div_init),
    .iter  (cmd.div_iter),
    .dmin  (dmin_r),
    .dmaj  (dmaj_r),
    .quot  (quot),
    .done  (div_done)
  );

  assign quot_ext = ACC_BITS'(quot);

  // Current pixel from the walk registers.
  assign minor   = minor_acc_r[ACC_BITS-1:FRAC_BITS];
  assign px      = steep_r ? lrd_pkg::PORT_BITS'(minor) : lrd_pkg::PORT_BITS'(major_pos_r);
  assign py      = steep_r ? lrd_pkg::PORT_BITS'(major_pos_r) : lrd_pkg::PORT_BITS'(minor);
  assign is_last = major_pos_r == major_end_r;

  // Next state of the line and the output register.
  always_comb begin
    active_nxt     = active_r;
    steep_nxt      = steep_r;
    neg_nxt        = neg_r;
    major_pos_nxt  = major_pos_r;
    major_end_nxt  = major_end_r;
    dmin_nxt       = dmin_r;
    dmaj_nxt       = dmaj_r;
    minor_acc_nxt  = minor_acc_r;
    minor_step_nxt = minor_step_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;

    if (cmd.load) begin
      active_nxt    = 1'b0;
      steep_nxt     = steep_in;
      neg_nxt       = m_hi < m_lo;
      major_pos_nxt = swap ? maj1 : maj0;
      major_end_nxt = swap ? maj0 : maj1;
      dmin_nxt      = steep_in ? dx : dy;
      dmaj_nxt      = steep_in ? dy : dx;
      minor_acc_nxt = ACC_BITS'(m_lo) << FRAC_BITS;
    end

    if (cmd.step_store) begin
      active_nxt = 1'b1;
      if (dmin_r == '0) begin
        minor_step_nxt = '0;
      end else begin
        minor_step_nxt = neg_r ? (ACC_BITS'(0) - quot_ext) : quot_ext;
      end
    end

    if (cmd.out_take) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.pixel) begin
      out_valid_nxt      = 1'b1;
      out_nxt.pixel_x    = px;
      out_nxt.pixel_y    = py;
      out_nxt.inside_res = (px < width_r) && (py < height_r);
      out_nxt.last       = is_last;
      if (is_last) begin
        active_nxt = 1'b0;
      end else begin
        major_pos_nxt = major_pos_r + 1'b1;
        minor_acc_nxt = minor_acc_r + minor_step_r;
      end
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      width_r     <= lrd_pkg::IMAGE_WIDTH_RST;
      height_r    <= lrd_pkg::IMAGE_HEIGHT_RST;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_idx == lrd_pkg::CFG_IMAGE_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_we && cfg_idx == lrd_pkg::CFG_IMAGE_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  // Walk registers and output payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steep_r      <= 1'b0;
      major_pos_r  <= '0;
      major_end_r  <= '0;
      minor_acc_r  <= '0;
      minor_step_r <= '0;
    end else begin
      steep_r      <= steep_nxt;
      major_pos_r  <= major_pos_nxt;
      major_end_r  <= major_end_nxt;
      minor_acc_r  <= minor_acc_nxt;
      minor_step_r <= minor_step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    dmin_r <= dmin_nxt;
    dmaj_r <= dmaj_nxt;
    out_r  <= out_nxt;
  end

  assign status.active    = active_r;
  assign status.no_div    = dmin_r == '0;
  assign status.div_done  = div_done;
  assign status.out_valid = out_valid_r;

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

endmodule

[rtl/core/lrd_ctrl.sv]
// Controller of the line rasterizer: input handshake and the sequence
// setup, divide, finish for a start item (setup only if no divide). Uses lrd_pkg.
`timescale 1ns / 1ps

module lrd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_stall,
  input  logic                out_stall,
  input  lrd_pkg::dp_status_t status,
  output lrd_pkg::ctrl_cmd_t  cmd
);

  lrd_pkg::state_t state_r, state_nxt;
  logic            in_acc;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Stall while a slope is computed or the output register cannot take a pixel.
  assign in_stall = (state_r != lrd_pkg::ST_IDLE) || (status.out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;

  // Next state and datapath commands.
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.out_take   = !out_stall;
    case (state_r)
      lrd_pkg::ST_IDLE: begin
        if (in_acc && in_command == lrd_pkg::CMD_START) begin
          cmd.load  = 1'b1;
          state_nxt = lrd_pkg::ST_SETUP;
        end
        if (in_acc && in_command == lrd_pkg::CMD_STEP && status.active) begin
          cmd.pixel = 1'b1;
        end
      end
      lrd_pkg::ST_SETUP: begin
        if (status.no_div) begin
          cmd.step_store = 1'b1;
          state_nxt      = lrd_pkg::ST_IDLE;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = lrd_pkg::ST_DIV;
        end
      end
      lrd_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_nxt = lrd_pkg::ST_FINISH;
        end else begin
          cmd.div_iter = 1'b1;
        end
      end
      lrd_pkg::ST_FINISH: begin
        cmd.step_store = 1'b1;
        state_nxt      = lrd_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lrd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/line_rasterizer_dda.sv]
// DDA line rasterizer top level. A step item gives its pixel in the output
// register in the cycle after it is taken; step items go at one per cycle unless
// the output stalls. A start item stalls input in setup, divide (one slope bit per
// cycle) and finish; horizontal, vertical and one-point lines stall in setup only.
// Synchronous active-low reset clears the line and sets width 640, height 480.
`timescale 1ns / 1ps

module line_rasterizer_dda #(
  parameter int COORD_BITS = lrd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lrd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lrd_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lrd_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lrd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lrd_pkg::PORT_BITS-1:0]     cfg_wdata
);

  lrd_pkg::ctrl_cmd_t  cmd;
  lrd_pkg::dp_status_t status;

  // Register writes are taken in every cycle.
  assign cfg_ready = 1'b1;

  lrd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .out_stall  (out_stall),
    .status     (status),
    .cmd        (cmd)
  );

  lrd_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_data  (cfg_wdata),
    .out_item  (out_data),
    .out_valid (out_valid)
  );

endmodule
